FILE: hw/rtl/utf8_to_cp1251_decoder_assert.svh
// Assertion macros shared by the checker of the transcoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UTF8_TO_CP1251_DECODER_ASSERT_SVH
`define UTF8_TO_CP1251_DECODER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define U8CP_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition in one cycle that requires another in the following cycle.
`define U8CP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

FILE: hw/rtl/u8cp_pkg.sv
`timescale 1ns / 1ps

package u8cp_pkg;

  localparam int CHAR_W          = 12;
  localparam int COUNT_MAX_DEF   = 4095;
  localparam logic [CHAR_W-1:0] MAX_CHARS_RESET = 12'd4095;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 24;
  localparam int Q_DEPTH         = 4;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_C2     = 8'hC2;
  localparam logic [7:0] LEAD_D0     = 8'hD0;
  localparam logic [7:0] LEAD_D1     = 8'hD1;
  localparam logic [7:0] LEAD_D2     = 8'hD2;
  localparam logic [7:0] LEAD_E2     = 8'hE2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] lead;
    logic [7:0] second;
    logic       failed;
  } state_t;

  typedef struct packed {
    logic [7:0]        code;
    kind_t             kind;
    logic [CHAR_W-1:0] count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic       three;
    logic [7:0] code;
  } match_t;

  function automatic match_t hit_code(input logic [7:0] code);
    match_t m;
    m.hit   = 1'b1;
    m.three = 1'b0;
    m.code  = code;
    return m;
  endfunction

  // True for the bytes that open at least one multi-byte table entry.
  function automatic logic is_lead(input logic [7:0] b);
    return (b == LEAD_C2) || (b == LEAD_D0) || (b == LEAD_D1) ||
           (b == LEAD_D2) || (b == LEAD_E2);
  endfunction

  // Lookup of a lead byte and the byte after it. For three-byte entries the
  // result only says that the pair is a valid prefix.
  function automatic match_t map2(input logic [7:0] lead, input logic [7:0] b);
    match_t m;
    m = '0;
    case (lead)
      LEAD_D0: begin
        if (b inside {[8'h90:8'hBF]}) begin
          m = hit_code(b + 8'h30);
        end else begin
          case (b)
            8'h82: m = hit_code(8'h80);
            8'h83: m = hit_code(8'h81);
            8'h89: m = hit_code(8'h8A);
            8'h8A: m = hit_code(8'h8C);
            8'h8C: m = hit_code(8'h8D);
            8'h8B: m = hit_code(8'h8E);
            8'h8F: m = hit_code(8'h8F);
            8'h8E: m = hit_code(8'hA1);
            8'h88: m = hit_code(8'hA3);
            8'h81: m = hit_code(8'hA8);
            8'h84: m = hit_code(8'hAA);
            8'h87: m = hit_code(8'hAF);
            8'h86: m = hit_code(8'hB2);
            8'h85: m = hit_code(8'hBD);
            default: m = '0;
          endcase
        end
      end
      LEAD_D1: begin
        if (b inside {[8'h80:8'h8F]}) begin
          m = hit_code(b + 8'h70);
        end else begin
          case (b)
            8'h93: m = hit_code(8'h83);
            8'h92: m = hit_code(8'h90);
            8'h99: m = hit_code(8'h9A);
            8'h9A: m = hit_code(8'h9C);
            8'h9C: m = hit_code(8'h9D);
            8'h9B: m = hit_code(8'h9E);
            8'h9F: m = hit_code(8'h9F);
            8'h9E: m = hit_code(8'hA2);
            8'h96: m = hit_code(8'hB3);
            8'h91: m = hit_code(8'hB8);
            8'h94: m = hit_code(8'hBA);
            8'h98: m = hit_code(8'hBC);
            8'h95: m = hit_code(8'hBE);
            8'h97: m = hit_code(8'hBF);
            default: m = '0;
          endcase
        end
      end
      LEAD_D2: begin
        case (b)
          8'h90: m = hit_code(8'hA5);
          8'h91: m = hit_code(8'hB4);
          default: m = '0;
        endcase
      end
      LEAD_C2: begin
        // Latin-1 symbols that keep their code point in the target set.
        if (b inside {8'hA0, 8'hA4, 8'hA6, 8'hA7, 8'hA9, 8'hAB, 8'hAC, 8'hAD,
                      8'hAE, 8'hB0, 8'hB1, 8'hB5, 8'hB6, 8'hB7, 8'hBB}) begin
          m = hit_code(b);
        end
      end
      LEAD_E2: begin
        if (b inside {8'h80, 8'h82, 8'h84}) begin
          m.hit   = 1'b1;
          m.three = 1'b1;
        end
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  // Lookup of the final byte of a three-byte sequence.
  function automatic match_t map3(input logic [7:0] lead, input logic [7:0] second,
                                  input logic [7:0] b);
    match_t m;
    m = '0;
    if (lead == LEAD_E2) begin
      case (second)
        8'h80: begin
          case (b)
            8'h9A: m = hit_code(8'h82);
            8'h9E: m = hit_code(8'h84);
            8'hA6: m = hit_code(8'h85);
            8'hA0: m = hit_code(8'h86);
            8'hA1: m = hit_code(8'h87);
            8'hB0: m = hit_code(8'h89);
            8'hB9: m = hit_code(8'h8B);
            8'h98: m = hit_code(8'h91);
            8'h99: m = hit_code(8'h92);
            8'h9C: m = hit_code(8'h93);
            8'h9D: m = hit_code(8'h94);
            8'hA2: m = hit_code(8'h95);
            8'h93: m = hit_code(8'h96);
            8'h94: m = hit_code(8'h97);
            8'hBA: m = hit_code(8'h9B);
            default: m = '0;
          endcase
        end
        8'h82: begin
          case (b)
            8'hAC: m = hit_code(8'h88);
            default: m = '0;
          endcase
        end
        8'h84: begin
          case (b)
            8'hA2: m = hit_code(8'h99);
            8'h96: m = hit_code(8'hB9);
            default: m = '0;
          endcase
        end
        default: m = '0;
      endcase
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/u8cp_step.sv
`timescale 1ns / 1ps

module u8cp_step #(
  parameter int COUNT_MAX = u8cp_pkg::COUNT_MAX_DEF
) (
  input  u8cp_pkg::state_t                   st,
  input  logic [$clog2(COUNT_MAX+1)-1:0]     cnt,
  input  logic [u8cp_pkg::CHAR_W-1:0]        max_chars,
  input  logic [7:0]                         in_byte,
  input  logic                               has_byte,
  input  logic                               ends_string,
  output u8cp_pkg::state_t                   st_next,
  output logic [$clog2(COUNT_MAX+1)-1:0]     cnt_next,
  output logic [1:0]                         n_res,
  output u8cp_pkg::result_t                  res_a,
  output u8cp_pkg::result_t                  res_b
);
  import u8cp_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int LIM_W = (CNT_W > CHAR_W) ? CNT_W : CHAR_W;

  logic [LIM_W-1:0] lim_cfg;
  logic [LIM_W-1:0] lim_cap;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] cnt_wide;
  logic             active;
  logic             emit;
  logic [7:0]       code;
  match_t           m2;
  match_t           m3;
  result_t          char_res;
  result_t          end_res;

  assign lim_cfg = LIM_W'(max_chars);
  assign lim_cap = LIM_W'(COUNT_MAX);
  assign limit   = (lim_cfg > lim_cap) ? lim_cap : lim_cfg;

  assign m2 = map2(st.lead, in_byte);
  assign m3 = map3(st.lead, st.second, in_byte);

  always_comb begin
    st_next  = st;
    emit     = 1'b0;
    code     = '0;
    active   = has_byte && !st.failed && (LIM_W'(cnt) < limit);
    if (active) begin
      case (st.phase)
        PH_IDLE: begin
          if (in_byte < ASCII_LIMIT) begin
            emit = 1'b1;
            code = in_byte;
          end else if (is_lead(in_byte)) begin
            st_next.lead  = in_byte;
            st_next.phase = PH_LEAD;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        PH_LEAD: begin
          if (m2.hit && m2.three) begin
            st_next.second = in_byte;
            st_next.phase  = PH_SECOND;
          end else begin
            st_next.phase = PH_IDLE;
            if (m2.hit) begin
              emit = 1'b1;
              code = m2.code;
            end else begin
              st_next.failed = 1'b1;
            end
          end
        end
        PH_SECOND: begin
          st_next.phase = PH_IDLE;
          if (m3.hit) begin
            emit = 1'b1;
            code = m3.code;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end

    cnt_next = emit ? cnt + 1'b1 : cnt;
    cnt_wide = LIM_W'(cnt_next);

    char_res.code  = code;
    char_res.kind  = KIND_CHAR;
    char_res.count = cnt_wide[CHAR_W-1:0];
    char_res.last  = 1'b0;

    // A string with an open sequence or a failure closes with an error.
    end_res.code = '0;
    end_res.last = 1'b1;
    if (st_next.failed || (st_next.phase != PH_IDLE)) begin
      end_res.kind  = KIND_ERR;
      end_res.count = '0;
    end else begin
      end_res.kind  = KIND_OK;
      end_res.count = cnt_wide[CHAR_W-1:0];
    end

    if (ends_string) begin
      st_next  = '0;
      cnt_next = '0;
    end

    res_a = emit ? char_res : end_res;
    res_b = end_res;
    n_res = 2'(emit) + 2'(ends_string);
  end

endmodule

FILE: hw/rtl/u8cp_outq.sv
`timescale 1ns / 1ps

module u8cp_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_n,
  input  u8cp_pkg::result_t  push_a,
  input  u8cp_pkg::result_t  push_b,
  input  logic               pop,
  output u8cp_pkg::result_t  head,
  output logic               not_empty,
  output logic               room
);
  import u8cp_pkg::*;

  localparam int PTR_W  = $clog2(Q_DEPTH);
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  result_t          mem [Q_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_plus;
  logic [FILL_W-1:0] fill;

  assign wr_ptr_plus = wr_ptr + 1'b1;
  assign head        = mem[rd_ptr];
  assign not_empty   = (fill != '0);
  // Room for the largest group of results that one item can produce.
  assign room        = (fill <= FILL_W'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + FILL_W'(push_n) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_plus] <= push_b;
    end
  end

endmodule

FILE: hw/rtl/utf8_to_cp1251_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_*       in         one UTF-8 byte, a has-byte flag and an end-of-string mark
// m_*       out        a Windows-1251 character or the end status of a string
// cfg_*     in         max_chars, the most characters emitted per string
//
// An item accepted on s_* is registered and decoded; once the queue has room,
// its results, none, one or two, land in a four-entry output queue that
// drives m_*. One item per cycle is sustained while the queue has room; an
// item with a character and an end result is delivered as two m_* transfers.
// s_tready drops only while the queue cannot take two more results.
// rst is synchronous and active high; it clears the decoder state, empties
// the queue and sets max_chars to 4095. cfg_ready is always high.

module utf8_to_cp1251_decoder #(
  parameter int COUNT_MAX = u8cp_pkg::COUNT_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [u8cp_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] in_byte
  input  logic                              s_tuser,   // [0] has_byte
  input  logic                              s_tlast,   // ends_string

  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [u8cp_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] out_code, [19:8] char_count
  output logic [1:0]                        m_tuser,   // [1:0] kind
  output logic                              m_tlast,   // last_of_string

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [u8cp_pkg::CHAR_W-1:0]       cfg_data   // max_chars
);
  import u8cp_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);

  // Input register: the accepted item waits here until the queue has room.
  logic              item_valid;
  logic [7:0]        item_byte;
  logic              item_has;
  logic              item_ends;

  // Per-string decoder state and the configuration register.
  state_t            st;
  state_t            st_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CHAR_W-1:0] max_chars;

  logic [1:0]        n_res;
  logic [1:0]        push_n;
  result_t           res_a;
  result_t           res_b;
  result_t           head;
  logic              q_room;
  logic              q_not_empty;
  logic              fire;

  // The registered item is decoded and retired in the same cycle whenever
  // the queue can take whatever it produces.
  assign fire      = item_valid && q_room;
  assign s_tready  = !item_valid || q_room;
  assign cfg_ready = 1'b1;
  assign push_n    = fire ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      st         <= '0;
      cnt        <= '0;
      max_chars  <= MAX_CHARS_RESET;
    end else begin
      if (s_tready) begin
        item_valid <= s_tvalid;
      end
      if (fire) begin
        st  <= st_next;
        cnt <= cnt_next;
      end
      if (cfg_valid) begin
        max_chars <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_byte <= s_tdata[7:0];
      item_has  <= s_tuser;
      item_ends <= s_tlast;
    end
  end

  // Sequence matching, the character limit and the end status.
  u8cp_step #(
    .COUNT_MAX (COUNT_MAX)
  ) u_step (
    .st          (st),
    .cnt         (cnt),
    .max_chars   (max_chars),
    .in_byte     (item_byte),
    .has_byte    (item_has),
    .ends_string (item_ends),
    .st_next     (st_next),
    .cnt_next    (cnt_next),
    .n_res       (n_res),
    .res_a       (res_a),
    .res_b       (res_b)
  );

  // The output queue decouples a stalled m_* side from the decoder.
  u8cp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .pop       (m_tvalid && m_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .room      (q_room)
  );

  assign m_tvalid = q_not_empty;
  assign m_tdata  = OUT_TDATA_W'({head.count, head.code});
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

endmodule

FILE: hw/rtl/u8cp_checker.sv
`timescale 1ns / 1ps

`include "utf8_to_cp1251_decoder_assert.svh"

module u8cp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [u8cp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic [1:0]                        m_tuser,
  input logic                              m_tlast
);
  import u8cp_pkg::*;

  // A result that is not taken stays offered.
  `U8CP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // A result that is not taken keeps its contents.
  `U8CP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // Only end results close a string, and every end result does.
  `U8CP_ASSERT_HOLDS(a_last_kind, m_tvalid |-> (m_tlast == (m_tuser != KIND_CHAR)), "tlast does not match the result kind")

  // A failed string reports no code and a zero count.
  `U8CP_ASSERT_HOLDS(a_err_zero, (m_tvalid && (m_tuser == KIND_ERR)) |-> (m_tdata == '0), "error result carries data")

endmodule

bind utf8_to_cp1251_decoder u8cp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: sim/utf8_to_cp1251_decoder_test.sv
`timescale 1ns / 1ps

import u8cp_pkg::*;

// Scoreboard that tracks the decoder state of the current string and keeps
// the results that the accepted bytes are expected to produce, oldest first.
class cp1251_scoreboard;
  int unsigned max_chars;
  phase_t      seq_phase;
  logic [7:0]  lead;
  logic [7:0]  second;
  int unsigned emitted;
  bit          failed;
  int unsigned mismatches;
  result_t     expected_codes[$];
  bit [23:0]   low_half[64];

  function new();
    // Sequences {lead, second, third} for codes 0x80..0xBF; 0x98 has none.
    low_half = '{
      24'hD08200, 24'hD08300, 24'hE2809A, 24'hD19300,
      24'hE2809E, 24'hE280A6, 24'hE280A0, 24'hE280A1,
      24'hE282AC, 24'hE280B0, 24'hD08900, 24'hE280B9,
      24'hD08A00, 24'hD08C00, 24'hD08B00, 24'hD08F00,
      24'hD19200, 24'hE28098, 24'hE28099, 24'hE2809C,
      24'hE2809D, 24'hE280A2, 24'hE28093, 24'hE28094,
      24'h000000, 24'hE284A2, 24'hD19900, 24'hE280BA,
      24'hD19A00, 24'hD19C00, 24'hD19B00, 24'hD19F00,
      24'hC2A000, 24'hD08E00, 24'hD19E00, 24'hD08800,
      24'hC2A400, 24'hD29000, 24'hC2A600, 24'hC2A700,
      24'hD08100, 24'hC2A900, 24'hD08400, 24'hC2AB00,
      24'hC2AC00, 24'hC2AD00, 24'hC2AE00, 24'hD08700,
      24'hC2B000, 24'hC2B100, 24'hD08600, 24'hD19600,
      24'hD29100, 24'hC2B500, 24'hC2B600, 24'hC2B700,
      24'hD19100, 24'hE28496, 24'hD19400, 24'hC2BB00,
      24'hD19800, 24'hD08500, 24'hD19500, 24'hD19700
    };
    max_chars  = COUNT_MAX_DEF;
    mismatches = 0;
    clear_string();
  endfunction

  // Byte sequence of Windows-1251 code k + 128; a zero third byte means two bytes.
  function bit [23:0] seq_of(int unsigned k);
    if (k < 64) begin
      return low_half[k];
    end else if (k < 112) begin
      return {LEAD_D0, 8'(8'h90 + k - 64), 8'h00};
    end
    return {LEAD_D1, 8'(8'h80 + k - 112), 8'h00};
  endfunction

  function void clear_string();
    seq_phase = PH_IDLE;
    lead      = 8'h00;
    second    = 8'h00;
    emitted   = 0;
    failed    = 1'b0;
  endfunction

  function void note_item(logic [7:0] b, bit has, bit ends);
    int unsigned limit;
    int          code;
    bit          hit;
    bit          starts;
    bit [23:0]   s;
    result_t     r;
    limit = (max_chars > COUNT_MAX_DEF) ? COUNT_MAX_DEF : max_chars;
    code  = -1;
    if (has && !failed && emitted < limit) begin
      case (seq_phase)
        PH_LEAD: begin
          hit = 1'b0;
          for (int k = 0; k < 128; k++) begin
            s = seq_of(k);
            if (!hit && s[23:16] == lead && s[15:8] == b) begin
              hit = 1'b1;
              if (s[7:0] == 8'h00) begin
                code      = k + 128;
                seq_phase = PH_IDLE;
              end else begin
                second    = b;
                seq_phase = PH_SECOND;
              end
            end
          end
          if (!hit) begin
            failed    = 1'b1;
            seq_phase = PH_IDLE;
          end
        end
        PH_SECOND: begin
          for (int k = 0; k < 128; k++) begin
            s = seq_of(k);
            if (code < 0 && s[7:0] != 8'h00 && s[23:16] == lead && s[15:8] == second &&
                s[7:0] == b) begin
              code = k + 128;
            end
          end
          if (code < 0) failed = 1'b1;
          seq_phase = PH_IDLE;
        end
        default: begin
          if (b < ASCII_LIMIT) begin
            code = int'(b);
          end else begin
            starts = 1'b0;
            for (int k = 0; k < 128; k++) begin
              s = seq_of(k);
              if (s[23:16] == b) starts = 1'b1;
            end
            if (starts) begin
              lead      = b;
              seq_phase = PH_LEAD;
            end else begin
              failed    = 1'b1;
              seq_phase = PH_IDLE;
            end
          end
        end
      endcase
      if (code >= 0) begin
        emitted = emitted + 1;
        r.code  = 8'(code);
        r.kind  = KIND_CHAR;
        r.count = 12'(emitted);
        r.last  = 1'b0;
        expected_codes.push_back(r);
      end
    end
    if (ends) begin
      r.code = 8'h00;
      r.last = 1'b1;
      if (failed || seq_phase != PH_IDLE) begin
        r.kind  = KIND_ERR;
        r.count = '0;
      end else begin
        r.kind  = KIND_OK;
        r.count = 12'(emitted);
      end
      expected_codes.push_back(r);
      clear_string();
    end
  endfunction

  task report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_output(logic [7:0] code, logic [1:0] kind, logic [11:0] count, logic last);
    result_t want;
    if (expected_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected result code %02h kind %0d count %0d last %0b",
                                code, kind, count, last));
      return;
    end
    want = expected_codes.pop_front();
    if (code !== want.code || kind !== want.kind || count !== want.count ||
        last !== want.last) begin
      report_mismatch($sformatf(
        "code %02h kind %0d count %0d last %0b, wanted code %02h kind %0d count %0d last %0b",
        code, kind, count, last, want.code, want.kind, want.count, want.last));
    end
  endtask
endclass

module utf8_to_cp1251_decoder_test;

  // Cycles the receiver holds off once, long enough to fill the output queue.
  localparam int HOLD_OFF_CYCLES = 60;
  // Cycles allowed to pass after the last result before a register write or
  // the end of the run.
  localparam int SETTLE_CYCLES   = 6;
  // Cycles without any transaction after which the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 1000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CHAR_W-1:0]      cfg_data;

  cp1251_scoreboard code_board = new();

  // Byte and end transactions sent so far; empty items are not counted.
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  // When clear, neither side inserts random idle cycles.
  bit          idle_enabled = 1'b1;
  // Set by the stimulus to make the receiver hold off once.
  bit          hold_off_req = 1'b0;

  utf8_to_cp1251_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] in_byte
    .s_tuser   (s_tuser),    // [0] has_byte
    .s_tlast   (s_tlast),    // ends_string
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] out_code, [19:8] char_count
    .m_tuser   (m_tuser),    // [1:0] kind
    .m_tlast   (m_tlast),    // last_of_string
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // max_chars
  );

  // The clock has a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every output transaction is checked against the oldest expected result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      code_board.check_output(m_tdata[7:0], m_tuser, m_tdata[19:8], m_tlast);
    end
  end

  // The watchdog ends the run when no transaction of any kind happens for
  // too long, which only a hung block can cause.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // The receiver is ready most of the time and drops tready at random, with a
  // chance of 7 percent. On request it holds off for a long stretch, counted
  // here, so that the output queue fills and the block stalls its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= !(idle_enabled && $urandom_range(99) < 7);
      end
    end
  end

  // Offers one item at a falling edge, after random idle cycles, and holds it
  // until the transaction completes at a rising edge. tvalid stays high when
  // the next call follows at once.
  task automatic send_item(input logic [7:0] b, input bit has, input bit ends);
    @(negedge clk);
    while (idle_enabled && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    code_board.note_item(b, has, ends);
    if (has || ends) items_sent++;
  endtask

  // The register is only written while the decoder is idle: input stopped,
  // every expected result delivered and a few cycles let pass.
  task automatic write_max_chars(input logic [CHAR_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (code_board.expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    code_board.max_chars = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_lead();
    case ($urandom_range(4))
      0:       return LEAD_C2;
      1:       return LEAD_D0;
      2:       return LEAD_D1;
      3:       return LEAD_D2;
      default: return LEAD_E2;
    endcase
  endfunction

  // Sends one string of about n_chars characters, mostly well formed. About
  // one string in five is broken: an unknown lead byte, a lead followed by a
  // random byte, a sequence left open at the end, or plain noise. The end
  // rides on the last byte or comes as an end-only item.
  task automatic send_string(input int unsigned n_chars);
    logic [7:0]  seq[$];
    logic [7:0]  v;
    int unsigned flaw;
    int unsigned k;
    int unsigned pos;
    bit [23:0]   s;
    bit          end_on_byte;
    flaw = $urandom_range(99);
    for (int unsigned i = 0; i < n_chars; i++) begin
      if ($urandom_range(99) < 35) begin
        seq.push_back(8'($urandom_range(127)));
      end else begin
        k = $urandom_range(127);
        if (k == 24) k = 25;
        s = code_board.seq_of(k);
        seq.push_back(s[23:16]);
        seq.push_back(s[15:8]);
        if (s[7:0] != 8'h00) seq.push_back(s[7:0]);
      end
    end
    pos = $urandom_range(seq.size());
    if (flaw < 6) begin
      do begin
        v = 8'($urandom_range(128, 255));
      end while (v inside {LEAD_C2, LEAD_D0, LEAD_D1, LEAD_D2, LEAD_E2});
      seq.insert(pos, v);
    end else if (flaw < 12) begin
      v = random_lead();
      seq.insert(pos, 8'($urandom_range(255)));
      if (v == LEAD_E2 && $urandom_range(1)) begin
        seq.insert(pos, 8'(8'h80 + 2 * $urandom_range(2)));
      end
      seq.insert(pos, v);
    end else if (flaw < 18) begin
      v = random_lead();
      seq.push_back(v);
      if (v == LEAD_E2 && $urandom_range(1)) seq.push_back(8'(8'h80 + 2 * $urandom_range(2)));
    end else if (flaw < 22) begin
      repeat ($urandom_range(1, 6)) seq.insert(pos, 8'($urandom_range(255)));
    end
    end_on_byte = (seq.size() != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < seq.size(); i++) begin
      // An occasional empty item must leave the decoder untouched.
      if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(seq[i], 1'b1, end_on_byte && (i == seq.size() - 1));
    end
    if (!end_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // One setting of max_chars with random strings until n_items transactions
  // have been sent. Short strings are used so that small limits are reached.
  task automatic run_phase(input logic [CHAR_W-1:0] limit, input int unsigned n_items,
                           input bit quiet, input bit hold_off);
    int unsigned stop_at;
    write_max_chars(limit);
    idle_enabled = !quiet;
    if (hold_off) begin
      @(posedge clk);
      hold_off_req = 1'b1;
    end
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_string($urandom_range(12));
    idle_enabled = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset limit of 4095. The zero byte and 0x7F
    // pass through; then a hit for each two-byte lead and two of the three
    // three-byte prefixes; an end-only item closes the string at count eight.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(LEAD_D0, 1'b1, 1'b0);
    send_item(8'h90, 1'b1, 1'b0);
    send_item(LEAD_D1, 1'b1, 1'b0);
    send_item(8'h8F, 1'b1, 1'b0);
    send_item(LEAD_C2, 1'b1, 1'b0);
    send_item(8'hA0, 1'b1, 1'b0);
    send_item(LEAD_D2, 1'b1, 1'b0);
    send_item(8'h91, 1'b1, 1'b0);
    send_item(LEAD_E2, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h9A, 1'b1, 1'b0);
    send_item(LEAD_E2, 1'b1, 1'b0);
    send_item(8'h84, 1'b1, 1'b0);
    send_item(8'h96, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    // An empty item yields nothing.
    send_item(8'hA5, 1'b0, 1'b0);
    // An unknown lead byte that also ends its string.
    send_item(8'hFF, 1'b1, 1'b1);
    // A continuation below 0x80 fails; the byte after it is swallowed.
    send_item(LEAD_D0, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h42, 1'b1, 1'b1);
    // A three-byte sequence still open when the string ends.
    send_item(LEAD_E2, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // With a limit of zero every byte is ignored and the count stays zero.
    write_max_chars('0);
    send_item(8'h41, 1'b1, 1'b1);

    // Random part over several limits, the extremes among them. The first
    // phase has the long receiver hold-off, one phase runs without idling.
    run_phase(12'd4095, 450, 1'b0, 1'b1);
    run_phase(12'd1, 150, 1'b0, 1'b0);
    run_phase(12'd3, 200, 1'b0, 1'b0);
    run_phase(12'd0, 100, 1'b0, 1'b0);
    run_phase(12'($urandom_range(4, 15)), 400, 1'b1, 1'b0);
    run_phase(12'($urandom_range(16, 4095)), 300, 1'b0, 1'b0);
    run_phase(12'd4095, 350, 1'b0, 1'b0);

    // Drain the remaining results and give the block time to show any extra.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (code_board.expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (code_board.expected_codes.size() != 0) begin
      code_board.report_mismatch($sformatf("%0d expected results never arrived",
                                           code_board.expected_codes.size()));
    end
    if (code_board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/u8cp_pkg.sv
hw/rtl/u8cp_step.sv
hw/rtl/u8cp_outq.sv
hw/rtl/utf8_to_cp1251_decoder.sv
hw/rtl/u8cp_checker.sv
sim/utf8_to_cp1251_decoder_test.sv
